// ===== sv/sdd_pkg.sv =====
// Shared types and constants for the soft surface dent displacer.
// Used by sdd_ctrl, sdd_datapath and the top level; no dependencies.
package sdd_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_VERTEX = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;  // accepted and dropped

    // Configuration register indexes
    localparam logic [2:0] CFG_PT_X   = 3'd0;
    localparam logic [2:0] CFG_PT_Y   = 3'd1;
    localparam logic [2:0] CFG_PT_Z   = 3'd2;
    localparam logic [2:0] CFG_N_X    = 3'd3;
    localparam logic [2:0] CFG_N_Y    = 3'd4;
    localparam logic [2:0] CFG_N_Z    = 3'd5;
    localparam logic [2:0] CFG_BUDGET = 3'd6;
    localparam logic [2:0] CFG_RADIUS = 3'd7;

    localparam logic [30:0] DEFAULT_RADIUS = 31'd14418;  // 0.22 m
    localparam logic [30:0] RADIUS_MIN    = 31'd6;      // at or below: use default
    localparam logic [17:0] NORMAL_Y_RST  = 18'd65536;
    localparam logic [16:0] MASS_ONE      = 17'd65536;
    localparam logic [23:0] TALLY_MAX     = 24'hFFFFFF;
    localparam logic [3:0]  DIV_LAST      = 4'd15;

    typedef struct packed {
        logic signed [31:0] pt_x;
        logic signed [31:0] pt_y;
        logic signed [31:0] pt_z;
        logic signed [17:0] n_x;
        logic signed [17:0] n_y;
        logic signed [17:0] n_z;
        logic [30:0]        budget;
        logic [30:0]        radius;
    } sdd_cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD, ST_H1, ST_H2, ST_H3, ST_D1, ST_D2, ST_D3,
        ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_DIV, ST_W1, ST_W2,
        ST_OFF, ST_OUT
    } sdd_state_t;

    typedef struct packed {
        sdd_state_t step;       // datapath step for this cycle
        logic       accept;     // input beat taken
        logic       next_bone;  // advance bone index
        logic       out_load;   // load output register
    } sdd_cmd_t;

    typedef struct packed {
        logic no_bones;
        logic last_bone;
        logic h_skip;
        logic far;
        logic d_skip;
        logic div_last;
        logic out_free;
    } sdd_status_t;

endpackage

// ===== sv/sdd_ctrl.sv =====
// Sequencer for the soft surface dent displacer: walks each vertex over
// the bone set. Depends on sdd_pkg.
module sdd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           opcode,
    input  sdd_pkg::sdd_status_t status,
    output sdd_pkg::sdd_cmd_t    cmd
);

    sdd_pkg::sdd_state_t state_reg;
    sdd_pkg::sdd_state_t state_next;
    sdd_pkg::sdd_state_t bone_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.step      = state_reg;
        cmd.accept    = 1'b0;
        cmd.next_bone = 1'b0;
        cmd.out_load  = 1'b0;
        s_tready      = (state_reg == sdd_pkg::ST_IDLE);
        bone_end      = status.last_bone ? sdd_pkg::ST_OFF : sdd_pkg::ST_RD;
        unique case (state_reg)
            sdd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (opcode == sdd_pkg::OP_VERTEX)
                    begin
                        state_next = status.no_bones ? sdd_pkg::ST_OFF : sdd_pkg::ST_RD;
                    end
                end
            end
            sdd_pkg::ST_RD: state_next = sdd_pkg::ST_H1;
            sdd_pkg::ST_H1: state_next = sdd_pkg::ST_H2;
            sdd_pkg::ST_H2: state_next = sdd_pkg::ST_H3;
            sdd_pkg::ST_H3:
            begin
                if (status.h_skip)
                begin
                    cmd.next_bone = 1'b1;
                    state_next    = bone_end;
                end
                else
                begin
                    state_next = sdd_pkg::ST_D1;
                end
            end
            sdd_pkg::ST_D1: state_next = sdd_pkg::ST_D2;
            sdd_pkg::ST_D2: state_next = sdd_pkg::ST_D3;
            sdd_pkg::ST_D3: state_next = sdd_pkg::ST_T1;
            sdd_pkg::ST_T1: state_next = sdd_pkg::ST_T2;
            sdd_pkg::ST_T2: state_next = sdd_pkg::ST_T3;
            sdd_pkg::ST_T3:
            begin
                if (status.far)
                begin
                    cmd.next_bone = 1'b1;
                    state_next    = bone_end;
                end
                else
                begin
                    state_next = sdd_pkg::ST_T4;
                end
            end
            sdd_pkg::ST_T4: state_next = sdd_pkg::ST_T5;
            sdd_pkg::ST_T5:
            begin
                if (status.d_skip)
                begin
                    cmd.next_bone = 1'b1;
                    state_next    = bone_end;
                end
                else
                begin
                    state_next = sdd_pkg::ST_DIV;
                end
            end
            sdd_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = sdd_pkg::ST_W1;
                end
            end
            sdd_pkg::ST_W1: state_next = sdd_pkg::ST_W2;
            sdd_pkg::ST_W2:
            begin
                cmd.next_bone = 1'b1;
                state_next    = bone_end;
            end
            sdd_pkg::ST_OFF: state_next = sdd_pkg::ST_OUT;
            sdd_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sdd_pkg::ST_IDLE;
                end
            end
            default: state_next = sdd_pkg::ST_IDLE;
        endcase
    end

    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdd_pkg::ST_DIV) && !status.div_last |=> state_reg == sdd_pkg::ST_DIV)
        else $error("divider left early");

    a_vertex_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && (opcode == sdd_pkg::OP_VERTEX) |=> state_reg != sdd_pkg::ST_IDLE)
        else $error("vertex beat dropped");

endmodule

// ===== sv/sdd_datapath.sv =====
// Datapath of the soft surface dent displacer: bone store, per-bone kernel
// arithmetic, restoring divider, tally and output register. Depends on sdd_pkg.
module sdd_datapath
#(
    parameter int MAX_BONES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdd_pkg::sdd_cmd_t    cmd,
    output sdd_pkg::sdd_status_t status,
    input  sdd_pkg::sdd_cfg_t    cfg,
    input  logic [1:0]           opcode,
    input  logic [3:0]           bone_slot,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic [30:0]          sphere_radius,
    input  logic [16:0]          mass_fraction,
    input  logic                 last_vertex,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic signed [31:0]   new_x,
    output logic signed [31:0]   new_y,
    output logic signed [31:0]   new_z,
    output logic                 was_displaced,
    output logic [23:0]          moved_count,
    output logic                 end_of_mesh
);

    localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int CW = $clog2(MAX_BONES + 1);

    // bone store
    logic signed [31:0] mem_x [MAX_BONES];
    logic signed [31:0] mem_y [MAX_BONES];
    logic signed [31:0] mem_z [MAX_BONES];
    logic [30:0]        mem_rad [MAX_BONES];
    logic [16:0]        mem_mass [MAX_BONES];

    logic signed [31:0] bp_reg [3];
    logic [30:0]        rad_reg;
    logic [16:0]        mass_reg;
    logic signed [31:0] p_reg [3];
    logic               last_reg;

    logic [CW-1:0]      active_reg;
    logic [CW-1:0]      idx_reg;
    logic               slot_ok;

    logic signed [62:0] prod_reg [3];
    logic signed [62:0] prod_next [3];
    logic signed [62:0] sum63;
    logic signed [36:0] h_reg;
    logic signed [40:0] dv_reg [3];
    logic signed [44:0] dn_reg;
    logic signed [47:0] t_reg [3];
    logic [47:0]        ta [3];
    logic [61:0]        sq_reg [3];
    logic [61:0]        sq_next [3];
    logic [63:0]        d2_reg;
    logic [61:0]        r2_reg;
    logic [61:0]        rem_reg;
    logic [62:0]        rem_sh;
    logic [15:0]        x2_reg;
    logic [3:0]         div_cnt_reg;
    logic [31:0]        bm_reg;
    logic [47:0]        bm_full;
    logic [16:0]        mass_c;
    logic [16:0]        om;
    logic [32:0]        om_sq;
    logic [16:0]        w_reg;
    logic [48:0]        dent_full;
    logic [32:0]        depth_reg;
    logic [30:0]        r_eff;
    logic signed [17:0] nvec [3];
    logic signed [31:0] ptv [3];
    logic signed [37:0] h_lim;

    logic signed [32:0] dh [3];
    logic signed [50:0] ph [3];
    logic signed [54:0] pnh [3];
    logic signed [40:0] dv_n [3];
    logic signed [58:0] pd [3];
    logic signed [62:0] pt1 [3];
    logic signed [47:0] t_n [3];
    logic signed [51:0] po [3];
    logic signed [36:0] vout [3];
    logic signed [31:0] vsat [3];
    logic [2:0]         far_k;

    logic               m_valid_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic               disp_reg, eom_reg;
    logic [23:0]        cnt_reg;
    logic [23:0]        tally_reg;
    logic [23:0]        tally_new;
    logic               moved;

    assign nvec[0] = cfg.n_x;
    assign nvec[1] = cfg.n_y;
    assign nvec[2] = cfg.n_z;
    assign ptv[0]  = cfg.pt_x;
    assign ptv[1]  = cfg.pt_y;
    assign ptv[2]  = cfg.pt_z;
    assign r_eff   = (cfg.radius > sdd_pkg::RADIUS_MIN) ? cfg.radius : sdd_pkg::DEFAULT_RADIUS;
    assign slot_ok = (32'(bone_slot) < MAX_BONES);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dh[k]   = 33'(bp_reg[k]) - 33'(ptv[k]);
            ph[k]   = dh[k] * nvec[k];
            pnh[k]  = nvec[k] * h_reg;
            dv_n[k] = 41'(p_reg[k]) - 41'(bp_reg[k]) + 41'($signed(prod_reg[k][54:16]));
            pd[k]   = dv_reg[k] * nvec[k];
            pt1[k]  = nvec[k] * dn_reg;
            t_n[k]  = 48'(dv_reg[k]) - 48'($signed(prod_reg[k][62:16]));
            ta[k]   = t_reg[k][47] ? 48'(-t_reg[k]) : 48'(t_reg[k]);
            far_k[k] = (ta[k] >= 48'(r_eff));
            sq_next[k] = 62'(ta[k][30:0]) * 62'(ta[k][30:0]);
            po[k]   = nvec[k] * $signed({1'b0, depth_reg});
            vout[k] = 37'(p_reg[k]) - 37'($signed(prod_reg[k][51:16]));
            if (vout[k] > 37'sh07FFFFFFF)
            begin
                vsat[k] = 32'sh7FFFFFFF;
            end
            else if (vout[k] < -37'sh080000000)
            begin
                vsat[k] = -32'sh80000000;
            end
            else
            begin
                vsat[k] = vout[k][31:0];
            end
            case (cmd.step)
                sdd_pkg::ST_H1:  prod_next[k] = 63'(ph[k]);
                sdd_pkg::ST_H3:  prod_next[k] = 63'(pnh[k]);
                sdd_pkg::ST_D2:  prod_next[k] = 63'(pd[k]);
                sdd_pkg::ST_T1:  prod_next[k] = pt1[k];
                sdd_pkg::ST_OFF: prod_next[k] = 63'(po[k]);
                default:         prod_next[k] = prod_reg[k];
            endcase
        end
    end

    assign sum63     = prod_reg[0] + prod_reg[1] + prod_reg[2];
    assign h_lim     = $signed({7'b0, rad_reg}) + 38'sd66;
    assign mass_c    = (mass_reg > sdd_pkg::MASS_ONE) ? sdd_pkg::MASS_ONE : mass_reg;
    assign bm_full   = 48'(cfg.budget) * 48'(mass_c);
    assign rem_sh    = {rem_reg, 1'b0};
    assign om        = sdd_pkg::MASS_ONE - {1'b0, x2_reg};
    assign om_sq     = 33'(om) * 33'(om);
    assign dent_full = 49'(bm_reg) * 49'(w_reg);
    assign moved     = (depth_reg != '0);
    assign tally_new = (moved && (tally_reg != sdd_pkg::TALLY_MAX)) ? tally_reg + 24'd1
                                                                      : tally_reg;

    assign status.no_bones  = (active_reg == '0);
    assign status.last_bone = ((idx_reg + CW'(1)) == active_reg);
    assign status.h_skip    = (38'(h_reg) > h_lim);
    assign status.far       = |far_k;
    assign status.d_skip    = (d2_reg >= 64'(r2_reg));
    assign status.div_last  = (div_cnt_reg == sdd_pkg::DIV_LAST);
    assign status.out_free  = !m_valid_reg || m_tready;

    // bone store write and read
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (opcode == sdd_pkg::OP_LOAD) && slot_ok)
        begin
            mem_x[AW'(bone_slot)]    <= pos_x;
            mem_y[AW'(bone_slot)]    <= pos_y;
            mem_z[AW'(bone_slot)]    <= pos_z;
            mem_rad[AW'(bone_slot)]  <= sphere_radius;
            mem_mass[AW'(bone_slot)] <= mass_fraction;
        end
        if (cmd.step == sdd_pkg::ST_RD)
        begin
            bp_reg[0] <= mem_x[idx_reg[AW-1:0]];
            bp_reg[1] <= mem_y[idx_reg[AW-1:0]];
            bp_reg[2] <= mem_z[idx_reg[AW-1:0]];
            rad_reg   <= mem_rad[idx_reg[AW-1:0]];
            mass_reg  <= mem_mass[idx_reg[AW-1:0]];
        end
    end

    // arithmetic payload registers
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= prod_next[k];
        end
        if (cmd.accept)
        begin
            p_reg[0] <= pos_x;
            p_reg[1] <= pos_y;
            p_reg[2] <= pos_z;
            last_reg <= last_vertex;
            r2_reg   <= 62'(r_eff) * 62'(r_eff);
            depth_reg <= '0;
        end
        unique case (cmd.step)
            sdd_pkg::ST_H2: h_reg <= sum63[52:16];
            sdd_pkg::ST_D1:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    dv_reg[k] <= dv_n[k];
                end
            end
            sdd_pkg::ST_D3: dn_reg <= sum63[60:16];
            sdd_pkg::ST_T2:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    t_reg[k] <= t_n[k];
                end
            end
            sdd_pkg::ST_T3:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    sq_reg[k] <= sq_next[k];
                end
                bm_reg <= bm_full[47:16];
            end
            sdd_pkg::ST_T4: d2_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            sdd_pkg::ST_T5:
            begin
                rem_reg <= d2_reg[61:0];
                x2_reg  <= '0;
            end
            sdd_pkg::ST_DIV:
            begin
                if (rem_sh >= 63'(r2_reg))
                begin
                    rem_reg <= 62'(rem_sh - 63'(r2_reg));
                    x2_reg  <= {x2_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[61:0];
                    x2_reg  <= {x2_reg[14:0], 1'b0};
                end
            end
            sdd_pkg::ST_W1: w_reg <= om_sq[32:16];
            sdd_pkg::ST_W2:
            begin
                if (dent_full[48:16] > depth_reg)
                begin
                    depth_reg <= dent_full[48:16];
                end
            end
            default: ;
        endcase
        if (cmd.out_load)
        begin
            ox_reg   <= vsat[0];
            oy_reg   <= vsat[1];
            oz_reg   <= vsat[2];
            disp_reg <= moved;
            cnt_reg  <= tally_new;
            eom_reg  <= last_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            idx_reg     <= '0;
            div_cnt_reg <= '0;
            tally_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && (opcode == sdd_pkg::OP_LOAD) && slot_ok
                && (CW'({1'b0, bone_slot} + 5'd1) > active_reg))
            begin
                active_reg <= CW'({1'b0, bone_slot} + 5'd1);
            end
            else if (cmd.accept && (opcode == sdd_pkg::OP_CLEAR))
            begin
                active_reg <= '0;
            end
            if (cmd.accept)
            begin
                idx_reg <= '0;
            end
            else if (cmd.next_bone)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.step == sdd_pkg::ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            else
            begin
                div_cnt_reg <= '0;
            end
            if (cmd.out_load)
            begin
                tally_reg   <= last_reg ? '0 : tally_new;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign new_x         = ox_reg;
    assign new_y         = oy_reg;
    assign new_z         = oz_reg;
    assign was_displaced = disp_reg;
    assign moved_count   = cnt_reg;
    assign end_of_mesh   = eom_reg;

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_valid_reg)
        else $error("result load lost");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && disp_reg |-> cnt_reg != '0)
        else $error("displaced vertex with zero count");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == sdd_pkg::ST_T5) && !status.d_skip |=> div_cnt_reg == '0)
        else $error("divider count not cleared");

endmodule

// ===== sv/soft_surface_dent_displacer.sv =====
// Top level of the soft surface dent displacer: configuration registers,
// stream packing, controller and datapath. Depends on sdd_pkg, sdd_ctrl, sdd_datapath.
//
// Bone loads and bone-set clears leave the block idle. A vertex holds the
// block while it walks every active bone, then waits in ST_OUT until the
// output register is free, loads its result there and only then lets the
// next input beat in. Bones that fail the height test leave the pass after
// ST_H3, the tangential test after ST_T3, the radius test after ST_T5. A full
// pass through the shared kernel datapath is a bone store read, eleven
// multiply/add steps, a 16-step restoring divider that forms dist^2/R^2 and
// the weighting steps ST_W1, ST_W2. One vertex is in flight at a time; its
// result sits in an output register, so the next item is accepted while it waits.
// Configuration writes are taken in any cycle (cfg_ready is tied high) and
// are meant to happen while the block is idle.
module soft_surface_dent_displacer
#(
    parameter int MAX_BONES = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    // tdata: bone_slot[3:0], pos_x[35:4], pos_y[67:36], pos_z[99:68],
    //        sphere_radius[130:100], mass_fraction[147:131], zero pad[151:148]
    input  logic [151:0]  s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]    s_tuser,
    input  logic          s_tlast,
    // output stream
    output logic          m_tvalid,
    input  logic          m_tready,
    // tdata: new_x[31:0], new_y[63:32], new_z[95:64], moved_count[119:96]
    output logic [119:0]  m_tdata,
    // tuser: was_displaced[0]
    output logic          m_tuser,
    output logic          m_tlast,
    // configuration write channel
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    sdd_pkg::sdd_cfg_t    cfg_reg;
    sdd_pkg::sdd_cmd_t    cmd;
    sdd_pkg::sdd_status_t status;

    logic signed [31:0] new_x, new_y, new_z;
    logic [23:0]        moved_count;

    assign cfg_ready = 1'b1;

    // Register file; normals and lengths keep only their low bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pt_x   <= '0;
            cfg_reg.pt_y   <= '0;
            cfg_reg.pt_z   <= '0;
            cfg_reg.n_x    <= '0;
            cfg_reg.n_y    <= sdd_pkg::NORMAL_Y_RST;
            cfg_reg.n_z    <= '0;
            cfg_reg.budget <= '0;
            cfg_reg.radius <= sdd_pkg::DEFAULT_RADIUS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sdd_pkg::CFG_PT_X:   cfg_reg.pt_x   <= cfg_data;
                sdd_pkg::CFG_PT_Y:   cfg_reg.pt_y   <= cfg_data;
                sdd_pkg::CFG_PT_Z:   cfg_reg.pt_z   <= cfg_data;
                sdd_pkg::CFG_N_X:    cfg_reg.n_x    <= cfg_data[17:0];
                sdd_pkg::CFG_N_Y:    cfg_reg.n_y    <= cfg_data[17:0];
                sdd_pkg::CFG_N_Z:    cfg_reg.n_z    <= cfg_data[17:0];
                sdd_pkg::CFG_BUDGET: cfg_reg.budget <= cfg_data[30:0];
                sdd_pkg::CFG_RADIUS: cfg_reg.radius <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    sdd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    sdd_datapath #(.MAX_BONES(MAX_BONES)) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg_reg),
        .opcode        (s_tuser),
        .bone_slot     (s_tdata[3:0]),
        .pos_x         (s_tdata[35:4]),
        .pos_y         (s_tdata[67:36]),
        .pos_z         (s_tdata[99:68]),
        .sphere_radius (s_tdata[130:100]),
        .mass_fraction (s_tdata[147:131]),
        .last_vertex   (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .new_x         (new_x),
        .new_y         (new_y),
        .new_z         (new_z),
        .was_displaced (m_tuser),
        .moved_count   (moved_count),
        .end_of_mesh   (m_tlast)
    );

    assign m_tdata = {moved_count, new_z, new_y, new_x};

endmodule

// ===== bench/soft_surface_dent_displacer_test.sv =====
// Self-checking bench for soft_surface_dent_displacer: bone loads, vertex stream,
// plane/kernel register writes, random idling on both stream sides.
// Depends on sdd_pkg and the soft_surface_dent_displacer RTL.
module soft_surface_dent_displacer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBONES       = 16;
    localparam int STALL_LIMIT  = 20000;  // cycles without any beat
    localparam int HOLD_CYCLES  = 2500;   // long receiver hold-off
    localparam int PHASE_ITEMS  = 230;
    localparam int HEIGHT_SLACK = 66;     // 1e-3 m above the bone radius

    typedef struct {
        logic [1:0]         op;
        logic [3:0]         slot;
        logic signed [31:0] x, y, z;
        logic [30:0]        rad;
        logic [16:0]        mass;
        logic               last;
    } in_item_t;

    typedef struct {
        logic [31:0] x, y, z;
        logic        moved;
        logic [23:0] count;
        logic        eom;
    } dent_result_t;

    // Scoreboard: holds a private copy of bone set, plane and tally, predicts
    // the displaced vertex for each accepted vertex beat.
    class dent_scoreboard;
        logic signed [31:0] pt[3];
        logic signed [17:0] nrm[3];
        logic [30:0]        budget, radius;
        logic signed [31:0] bx[NBONES], by[NBONES], bz[NBONES];
        logic [30:0]        brad[NBONES];
        logic [16:0]        bmass[NBONES];
        int                 active;
        logic [23:0]        tally;
        dent_result_t       awaiting[$];
        int                 errors, results, displaced, vertices, loads;

        function new();
            pt = '{0, 0, 0};
            nrm = '{0, sdd_pkg::NORMAL_Y_RST, 0};
            budget = 0;
            radius = sdd_pkg::DEFAULT_RADIUS;
            active = 0;
            tally = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                sdd_pkg::CFG_PT_X:   pt[0] = d;
                sdd_pkg::CFG_PT_Y:   pt[1] = d;
                sdd_pkg::CFG_PT_Z:   pt[2] = d;
                sdd_pkg::CFG_N_X:    nrm[0] = d[17:0];
                sdd_pkg::CFG_N_Y:    nrm[1] = d[17:0];
                sdd_pkg::CFG_N_Z:    nrm[2] = d[17:0];
                sdd_pkg::CFG_BUDGET: budget = d[30:0];
                sdd_pkg::CFG_RADIUS: radius = d[30:0];
                default: ;
            endcase
        endfunction

        function void note_input(in_item_t it);
            longint p[3], ptl[3], nl[3], bp[3], dv[3], t[3];
            longint hq, h, dq, dn, a, v, onpl, rs;
            longint unsigned d2, r, r2, rem, x2, om, w, mass, dent, depth;
            bit far;
            dent_result_t res;
            logic [31:0] nc[3];
            p[0] = it.x; p[1] = it.y; p[2] = it.z;
            case (it.op)
                sdd_pkg::OP_LOAD:
                begin
                    bx[it.slot] = it.x; by[it.slot] = it.y; bz[it.slot] = it.z;
                    brad[it.slot] = it.rad;
                    bmass[it.slot] = it.mass;
                    if (int'(it.slot) + 1 > active) active = int'(it.slot) + 1;
                    loads++;
                end
                sdd_pkg::OP_CLEAR: active = 0;
                sdd_pkg::OP_VERTEX:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        ptl[k] = pt[k];
                        nl[k] = nrm[k];
                    end
                    r = (radius > sdd_pkg::RADIUS_MIN) ? radius : sdd_pkg::DEFAULT_RADIUS;
                    rs = longint'(r);
                    r2 = r * r;
                    depth = 0;
                    for (int b = 0; b < active && b < NBONES; b++)
                    begin
                        bp[0] = bx[b]; bp[1] = by[b]; bp[2] = bz[b];
                        hq = 0;
                        for (int k = 0; k < 3; k++) hq += (bp[k] - ptl[k]) * nl[k];
                        h = hq >>> 16;
                        if (h > longint'(brad[b]) + HEIGHT_SLACK) continue;
                        // vector from the bone's foot on the plane to the vertex
                        dq = 0;
                        for (int k = 0; k < 3; k++)
                        begin
                            onpl = bp[k] - ((nl[k] * h) >>> 16);
                            dv[k] = p[k] - onpl;
                            dq += dv[k] * nl[k];
                        end
                        dn = dq >>> 16;
                        far = 0;
                        for (int k = 0; k < 3; k++)
                        begin
                            t[k] = dv[k] - ((nl[k] * dn) >>> 16);
                            a = (t[k] < 0) ? -t[k] : t[k];
                            if (a >= rs) far = 1;
                        end
                        if (far) continue;
                        d2 = 0;
                        for (int k = 0; k < 3; k++)
                        begin
                            a = (t[k] < 0) ? -t[k] : t[k];
                            d2 += longint'(a * a);
                        end
                        if (d2 >= r2) continue;
                        // restoring division, 16 fraction bits of d2/R2
                        rem = d2;
                        x2 = 0;
                        for (int k = 0; k < 16; k++)
                        begin
                            rem = rem << 1;
                            x2 = x2 << 1;
                            if (rem >= r2)
                            begin
                                rem -= r2;
                                x2 |= 1;
                            end
                        end
                        om = 65536 - x2;
                        w = (om * om) >> 16;
                        mass = (bmass[b] > sdd_pkg::MASS_ONE) ? sdd_pkg::MASS_ONE : bmass[b];
                        dent = ((((longint'(budget)) * mass) >> 16) * w) >> 16;
                        if (dent > depth) depth = dent;
                    end
                    res.moved = (depth > 0);
                    for (int k = 0; k < 3; k++)
                    begin
                        v = p[k];
                        if (res.moved)
                        begin
                            v = v - ((nl[k] * longint'(depth)) >>> 16);
                            if (v > 64'sd2147483647) v = 64'sd2147483647;
                            if (v < -64'sd2147483648) v = -64'sd2147483648;
                        end
                        nc[k] = v[31:0];
                    end
                    res.x = nc[0]; res.y = nc[1]; res.z = nc[2];
                    if (res.moved && tally != sdd_pkg::TALLY_MAX) tally++;
                    res.count = tally;
                    res.eom = it.last;
                    if (it.last) tally = 0;
                    awaiting.push_back(res);
                    vertices++;
                end
                default: ;  // unused opcode: dropped
            endcase
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [119:0] d, logic u, logic l);
            dent_result_t e;
            if (awaiting.size() == 0)
            begin
                report($sformatf("result beat with nothing awaited, tdata=%h", d));
                return;
            end
            e = awaiting.pop_front();
            results++;
            if (u) displaced++;
            if (d[31:0] !== e.x) report($sformatf("new_x %h, want %h", d[31:0], e.x));
            if (d[63:32] !== e.y) report($sformatf("new_y %h, want %h", d[63:32], e.y));
            if (d[95:64] !== e.z) report($sformatf("new_z %h, want %h", d[95:64], e.z));
            if (d[119:96] !== e.count)
                report($sformatf("moved_count %0d, want %0d", d[119:96], e.count));
            if (u !== e.moved) report($sformatf("was_displaced %b, want %b", u, e.moved));
            if (l !== e.eom) report($sformatf("end_of_mesh %b, want %b", l, e.eom));
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          s_tvalid, s_tready, s_tlast;
    logic [151:0]  s_tdata;
    logic [1:0]    s_tuser;
    logic          m_tvalid, m_tready, m_tuser, m_tlast;
    logic [119:0]  m_tdata;
    logic          cfg_valid, cfg_ready;
    logic [2:0]    cfg_index;
    logic [31:0]   cfg_data;

    dent_scoreboard sb;
    int  send_idle_pct;   // chance per cycle that the sender holds back
    int  recv_stall_pct;  // chance per cycle that the receiver stalls
    bit  hold_req;        // ask the receiver for one long hold-off
    int  written_cnt;     // slots 0..written_cnt-1 hold a bone
    int  items_sent;
    int  quiet_cycles;
    longint eff_r;        // kernel radius in force, for shaping stimulus

    soft_surface_dent_displacer #(.MAX_BONES(NBONES)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or one long hold-off on request. While held,
    // the block's output register fills and s_tready must drop.
    initial
    begin
        m_tready = 0;
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    // Result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // One input beat; s_tvalid stays high so back-to-back beats need no gap.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {4'b0, it.mass, it.rad, it.z, it.y, it.x, it.slot};
        s_tuser  <= it.op;
        s_tlast  <= it.last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(it);
        if (it.op == sdd_pkg::OP_LOAD && int'(it.slot) == written_cnt) written_cnt++;
        if (it.op != sdd_pkg::OP_UNUSED) items_sent++;
    endtask

    // Stop sending and wait until every awaited vertex has come back.
    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (sb.awaiting.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, d);
    endtask

    // Registers only change with the block idle; loads leave no result, so
    // give the block a few cycles after the last one.
    task automatic configure(input logic [31:0] v[8]);
        drain();
        repeat (20) @(posedge clk);
        write_reg(sdd_pkg::CFG_PT_X, v[0]);
        write_reg(sdd_pkg::CFG_PT_Y, v[1]);
        write_reg(sdd_pkg::CFG_PT_Z, v[2]);
        write_reg(sdd_pkg::CFG_N_X, v[3]);
        write_reg(sdd_pkg::CFG_N_Y, v[4]);
        write_reg(sdd_pkg::CFG_N_Z, v[5]);
        write_reg(sdd_pkg::CFG_BUDGET, v[6]);
        write_reg(sdd_pkg::CFG_RADIUS, v[7]);
        cfg_valid <= 0;
        eff_r = (v[7][30:0] > sdd_pkg::RADIUS_MIN) ? longint'(v[7][30:0])
                                                    : longint'(sdd_pkg::DEFAULT_RADIUS);
    endtask

    // Fields are taken from the low bits of each argument.
    function automatic in_item_t mk(longint op, longint slot, longint x, longint y,
                                    longint z, longint rad, longint mass, longint last);
        in_item_t it;
        it.op = op[1:0]; it.slot = slot[3:0];
        it.x = x[31:0]; it.y = y[31:0]; it.z = z[31:0];
        it.rad = rad[30:0]; it.mass = mass[16:0]; it.last = last[0];
        return it;
    endfunction

    function automatic longint jitter(longint span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    // Well-formed mesh: clear, load k bones near the plane, then nv vertices
    // scattered around them, the last one flagged.
    task automatic mesh(input int k, input int nv);
        longint bpos[NBONES][3];
        longint span;
        in_item_t it;
        int b;
        span = (eff_r > 64'd16777216) ? 64'd16777216 : eff_r;
        send_item(mk(sdd_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom));
        for (int j = 0; j < k; j++)
        begin
            for (int a = 0; a < 3; a++) bpos[j][a] = longint'(sb.pt[a]) + jitter(span);
            it = mk(sdd_pkg::OP_LOAD, j, bpos[j][0], bpos[j][1], bpos[j][2],
                    ($urandom_range(3) == 0) ? $urandom : $urandom_range(span),
                    ($urandom_range(9) == 0) ? $urandom_range(131071, 65536)
                                             : $urandom_range(65536), $urandom);
            send_item(it);
        end
        for (int j = 0; j < nv; j++)
        begin
            b = $urandom_range(k - 1);
            it = mk(sdd_pkg::OP_VERTEX, $urandom, bpos[b][0] + jitter(span),
                    bpos[b][1] + jitter(span), bpos[b][2] + jitter(span), $urandom,
                    $urandom, j == nv - 1);
            send_item(it);
        end
    endtask

    // Noise: any opcode and any field values; loads only into slots that
    // keep the bone set free of unwritten entries.
    task automatic noise(input int n);
        in_item_t it;
        for (int j = 0; j < n; j++)
        begin
            it = mk($urandom_range(3), $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom_range(131071), $urandom);
            if (it.op == sdd_pkg::OP_LOAD)
                it.slot = 4'($urandom_range((written_cnt < 15) ? written_cnt : 15));
            send_item(it);
        end
    endtask

    function automatic logic [31:0] axis_normal(int axis, int which);
        logic [17:0] one;
        one = $urandom_range(1) ? 18'sd65536 : -18'sd65536;
        return (axis == which) ? {{14{one[17]}}, one} : 32'd0;
    endfunction

    initial
    begin
        logic [31:0] cv[8];
        int axis, target;
        s_tvalid = 0; s_tdata = '0; s_tuser = '0; s_tlast = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_req = 0;
        written_cnt = 0; items_sent = 0; quiet_cycles = 0;
        eff_r = sdd_pkg::DEFAULT_RADIUS;
        sb = new();
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part. First a vertex with reset registers and no bones.
        send_item(mk(sdd_pkg::OP_VERTEX, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0));
        // Full budget, plane through the origin, normal +y, default radius.
        cv = '{0, 0, 0, 0, sdd_pkg::NORMAL_Y_RST, 0, 32'h7fffffff, 0};
        configure(cv);
        // Bone at the origin, mass above one: heavy dent, y saturates low.
        send_item(mk(sdd_pkg::OP_LOAD, 0, 0, 0, 0, 0, 17'h1ffff, 0));
        send_item(mk(sdd_pkg::OP_VERTEX, 0, 0, 32'h80000000, 0, 0, 0, 0));
        // Vertex far off tangentially
        send_item(mk(sdd_pkg::OP_VERTEX, 0, 32'h7fffffff, 0, 32'h7fffffff, 0, 0, 0));
        // Bone high above the plane (height test fails), zero mass
        send_item(mk(sdd_pkg::OP_LOAD, 1, 0, 32'h40000000, 0, 0, 0, 0));
        // Huge sphere, mass exactly one
        send_item(mk(sdd_pkg::OP_LOAD, 2, 100, 0, 100, 31'h7fffffff, sdd_pkg::MASS_ONE, 0));
        send_item(mk(sdd_pkg::OP_VERTEX, 0, 100, 5, 100, 0, 0, 0));
        // Unused opcode with every field at its top
        send_item(mk(sdd_pkg::OP_UNUSED, 4'hf, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     31'h7fffffff, 17'h1ffff, 1));
        // Last vertex: tally reported then cleared
        send_item(mk(sdd_pkg::OP_VERTEX, 0, 0, 0, 0, 0, 0, 1));
        // Near the kernel edge, then fill the whole bone set
        send_item(mk(sdd_pkg::OP_VERTEX, 0, 14000, 0, 0, 0, 0, 0));
        for (int s = 3; s < NBONES; s++)
            send_item(mk(sdd_pkg::OP_LOAD, s, jitter(8000), jitter(8000), jitter(8000),
                         $urandom_range(20000), $urandom_range(65536), 0));
        send_item(mk(sdd_pkg::OP_VERTEX, 0, 300, -200, 500, 0, 0, 0));
        send_item(mk(sdd_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(sdd_pkg::OP_VERTEX, 0, 0, 0, 0, 0, 0, 1));

        // Random phases; idling pattern and registers change per phase.
        for (int ph = 0; ph < 8; ph++)
        begin
            axis = $urandom_range(2);
            for (int a = 0; a < 3; a++)
                cv[a] = (ph == 5) ? ((a == 0) ? 32'h80000000 : (a == 1) ? 32'h7fffffff : 0)
                                  : 32'(jitter(64'd268435456));
            for (int a = 0; a < 3; a++)
                cv[3 + a] = (ph % 3 == 0) ? axis_normal(axis, a) : 32'(jitter(65536));
            cv[6] = (ph == 3) ? 0 : (ph == 6) ? 32'h7fffffff : $urandom_range(16777216);
            cv[7] = (ph == 2) ? $urandom_range(6) : (ph == 4) ? 32'h7fffffff :
                    (ph == 7) ? 7 : $urandom_range(1048576, 1000);
            configure(cv);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (ph == 2) hold_req = 1;  // sender keeps offering meanwhile
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(4) != 0)
                    mesh(($urandom_range(9) == 0) ? NBONES : $urandom_range(4, 1),
                         $urandom_range(10, 1));
                else
                    noise($urandom_range(5, 1));
                // once, stop mid-phase until everything has drained
                if (ph == 1 && items_sent >= target - PHASE_ITEMS / 2 && send_idle_pct != 0)
                begin
                    drain();
                    send_idle_pct = 0;
                end
            end
        end

        drain();
        repeat (50) @(posedge clk);
        $display("Covered %0d input beats: %0d bone loads, %0d vertices, %0d results",
                 items_sent, sb.loads, sb.vertices, sb.results);
        $display("%0d vertices displaced, 9 register settings, %0d mismatches",
                 sb.displaced, sb.errors);
        if (sb.errors == 0 && sb.awaiting.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
